FILE: rtl/core/cpcs_pkg.sv
// Package: grid sizes, fixed-point constants, types and the microprogram of the cell step.
package cpcs_pkg;

	localparam int GRID_X    = 32;
	localparam int GRID_Y    = 32;
	localparam int GRID_A    = 16;
	localparam int FRAC_BITS = 16;
	localparam int SLICE     = GRID_X * GRID_Y;
	localparam int CELLS     = SLICE * GRID_A;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ENTRY_W   = 4 * 32 + 5;
	localparam int PC_W      = 5;

	localparam logic signed [31:0] Q_HALF = 32'(64'sd1 <<< (FRAC_BITS - 1));
	localparam logic signed [31:0] Q_ONE  = 32'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef enum logic [2:0] {
		CFG_DIFF, CFG_CHEMO, CFG_SX, CFG_SY, CFG_SA, CFG_RP, CFG_RM, CFG_AMAX
	} cfg_idx_t;

	typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL} alu_op_t;
	typedef enum logic [1:0] {U_ADD, U_SUB, U_SUBD, U_MUL} uop_op_t;

	typedef enum logic [4:0] {
		O_D = 5'd0, O_CHI, O_SX, O_SY, O_SA, O_RP, O_RM, O_AMAX,
		O_UC, O_CC, O_AC, O_IC, O_UN, O_CN, O_AN,
		O_HALF, O_ONE, O_ZERO, O_USEL, O_DF,
		O_T0, O_T1, O_T2, O_T3, O_T4, O_NHC,
		O_FE, O_FW, O_FN, O_FS, O_FAM, O_FAP
	} opnd_t;

	typedef struct packed {
		uop_op_t op;
		opnd_t   a;
		opnd_t   b;
		opnd_t   dst;
		logic    last;
	} uop_t;

	typedef enum logic [3:0] {
		S_IDLE, S_CLATCH, S_UOP, S_NEXT, S_NLATCH, S_TOTAL
	} state_t;

	typedef enum logic [2:0] {F_E, F_W, F_N, F_S, F_LO, F_HI, F_END} face_t;
	typedef enum logic [1:0] {P_NHC, P_FACE, P_FINAL} prog_t;

	typedef struct packed {
		logic signed [31:0] y;
		logic               flag;
	} sat_t;

	localparam logic [PC_W-1:0] PC_FACE  = 5'd0;
	localparam logic [PC_W-1:0] PC_PHENO = 5'd7;
	localparam logic [PC_W-1:0] PC_FINAL = 5'd17;
	localparam logic [PC_W-1:0] PC_NHC   = 5'd23;

	function automatic sat_t sat64(input logic signed [63:0] v);
		sat_t r;
		if (v > SAT_MAX) begin
			r.y = 32'sh7fffffff;
			r.flag = 1'b1;
		end else if (v < SAT_MIN) begin
			r.y = 32'sh80000000;
			r.flag = 1'b1;
		end else begin
			r.y = v[31:0];
			r.flag = 1'b0;
		end
		return r;
	endfunction

	function automatic uop_t mk(input uop_op_t op, input opnd_t a, input opnd_t b,
			input opnd_t d, input logic l);
		uop_t u;
		u.op = op;
		u.a = a;
		u.b = b;
		u.dst = d;
		u.last = l;
		return u;
	endfunction

	// x/y face flux, phenotype face flux, final gradients, then -chi/2
	function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			5'd0:  u = mk(U_SUBD, O_UN, O_UC, O_T0, 1'b0);
			5'd1:  u = mk(U_SUBD, O_CN, O_CC, O_T1, 1'b0);
			5'd2:  u = mk(U_MUL, O_D, O_T0, O_T0, 1'b0);
			5'd3:  u = mk(U_ADD, O_UN, O_UC, O_T2, 1'b0);
			5'd4:  u = mk(U_MUL, O_NHC, O_T2, O_T2, 1'b0);
			5'd5:  u = mk(U_MUL, O_T2, O_T1, O_T2, 1'b0);
			5'd6:  u = mk(U_ADD, O_T2, O_T0, O_DF, 1'b1);
			5'd7:  u = mk(U_ADD, O_AC, O_AN, O_T0, 1'b0);
			5'd8:  u = mk(U_MUL, O_HALF, O_T0, O_T0, 1'b0);
			5'd9:  u = mk(U_SUB, O_AMAX, O_T0, O_T1, 1'b0);
			5'd10: u = mk(U_MUL, O_RP, O_T1, O_T1, 1'b0);
			5'd11: u = mk(U_MUL, O_T1, O_IC, O_T1, 1'b0);
			5'd12: u = mk(U_MUL, O_RM, O_T0, O_T2, 1'b0);
			5'd13: u = mk(U_SUB, O_ONE, O_IC, O_T3, 1'b0);
			5'd14: u = mk(U_MUL, O_T2, O_T3, O_T2, 1'b0);
			5'd15: u = mk(U_SUB, O_T1, O_T2, O_T0, 1'b0);
			5'd16: u = mk(U_MUL, O_T0, O_USEL, O_DF, 1'b1);
			5'd17: u = mk(U_SUB, O_FE, O_FW, O_T0, 1'b0);
			5'd18: u = mk(U_MUL, O_T0, O_SX, O_T0, 1'b0);
			5'd19: u = mk(U_SUB, O_FN, O_FS, O_T1, 1'b0);
			5'd20: u = mk(U_MUL, O_T1, O_SY, O_T1, 1'b0);
			5'd21: u = mk(U_SUB, O_FAM, O_FAP, O_T2, 1'b0);
			5'd22: u = mk(U_MUL, O_T2, O_SA, O_T2, 1'b1);
			5'd23: u = mk(U_MUL, O_CHI, O_HALF, O_T4, 1'b0);
			5'd24: u = mk(U_SUB, O_ZERO, O_T4, O_NHC, 1'b1);
			default: u = mk(U_ADD, O_ZERO, O_ZERO, O_T4, 1'b1);
		endcase
		return u;
	endfunction

endpackage

FILE: rtl/core/chemotaxis_phenotype_pde_cell_step.sv
// Top level: cell store, microcoded sequencer and shared ALU for one masked PDE cell step.
// Load beat: written to the store at the accept edge, busy never rises.
// Compute beat: busy through center latch, -chi/2 program, face fluxes (zero if skipped),
// final gradients and total; off-grid or with the center bit clear it ends at the latch.
// Result: done is high for one cycle right after busy falls; a new beat may start then.
// Reset: arst_n clears the sequencer, the result strobe and the config registers only.
module chemotaxis_phenotype_pde_cell_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [4:0]         cell_x,
	input  logic [4:0]         cell_y,
	input  logic [3:0]         pheno_bin,
	input  logic signed [31:0] u_val,
	input  logic signed [31:0] conc_val,
	input  logic signed [31:0] trait_val,
	input  logic signed [31:0] ic_frac,
	input  logic [4:0]         face_mask,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               done,
	output logic signed [31:0] u_next,
	output logic               sat_flag
);
	import cpcs_pkg::*;

	// configuration
	logic signed [31:0] diff_q, chi_q, sx_q, sy_q, sa_q, rp_q, rm_q, amax_q;

	// sequencer
	state_t state_q, state_d;
	face_t  face_q;
	prog_t  prog_q;
	logic [PC_W-1:0] pc_q;
	logic   sat_q;

	// cell under work
	logic [4:0] x_q, y_q;
	logic [3:0] k_q;
	logic       inside_q;
	logic [ADDR_W-1:0] c_q;
	logic signed [31:0] uc_q, cc_q, ac_q, ic_q, un_q, cn_q, an_q;
	logic [4:0] m_q;

	// scratch and face fluxes
	logic signed [31:0] t0_q, t1_q, t2_q, t3_q, t4_q, nhc_q;
	logic signed [31:0] fe_q, fw_q, fn_q, fs_q, fam_q, fap_q;

	// result
	logic               done_q, res_sat_q;
	logic signed [31:0] res_q;

	// store
	logic               accept, inside_in, ram_we;
	logic [ADDR_W-1:0]  addr_in, rd_addr;
	logic [ENTRY_W-1:0] wr_entry, rd_entry;
	logic signed [31:0] rd_u, rd_c, rd_a, rd_i;
	logic [4:0]         rd_m;

	// execution
	uop_t               uop;
	opnd_t              dst_eff, face_dst;
	logic               wr_en;
	opnd_t              wr_dst;
	logic signed [31:0] wr_val;
	logic signed [31:0] opa, opb, alu_a, alu_b, alu_y;
	alu_op_t            alu_op;
	logic               alu_sat, face_en, f_le0, dir_neg;
	logic [ADDR_W-1:0]  nb_addr;
	sat_t               total;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign inside_in = (int'(cell_x) < GRID_X) && (int'(cell_y) < GRID_Y)
		&& (int'(pheno_bin) < GRID_A);
	assign addr_in = inside_in ? ADDR_W'(int'(pheno_bin) * SLICE + int'(cell_y) * GRID_X
		+ int'(cell_x)) : '0;
	assign ram_we = accept && !func && inside_in;
	assign wr_entry = {face_mask, ic_frac, trait_val, conc_val, u_val};

	cpcs_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_in),
		.wdata (wr_entry),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	assign rd_u = rd_entry[31:0];
	assign rd_c = rd_entry[63:32];
	assign rd_a = rd_entry[95:64];
	assign rd_i = rd_entry[127:96];
	assign rd_m = rd_entry[132:128];

	// face enable and neighbor address
	always_comb begin
		face_en = 1'b0;
		nb_addr = c_q;
		case (face_q)
			F_E: begin
				face_en = (int'(x_q) + 1 < GRID_X) && m_q[1];
				nb_addr = c_q + ADDR_W'(1);
			end
			F_W: begin
				face_en = (x_q != '0) && m_q[2];
				nb_addr = c_q - ADDR_W'(1);
			end
			F_N: begin
				face_en = (int'(y_q) + 1 < GRID_Y) && m_q[3];
				nb_addr = c_q + ADDR_W'(GRID_X);
			end
			F_S: begin
				face_en = (y_q != '0) && m_q[4];
				nb_addr = c_q - ADDR_W'(GRID_X);
			end
			F_LO: begin
				face_en = (k_q != '0);
				nb_addr = c_q - ADDR_W'(SLICE);
			end
			F_HI: begin
				face_en = (int'(k_q) + 1 < GRID_A);
				nb_addr = c_q + ADDR_W'(SLICE);
			end
			default: begin
				face_en = 1'b0;
				nb_addr = c_q;
			end
		endcase
	end

	assign uop = uop_rom(pc_q);
	assign face_dst = opnd_t'(5'(O_FE) + 5'(face_q));
	assign dst_eff = (uop.dst == O_DF) ? face_dst : uop.dst;
	assign f_le0 = t0_q[31] || (t0_q == '0);
	assign dir_neg = (face_q == F_W) || (face_q == F_S);

	function automatic logic signed [31:0] pick(input opnd_t s);
		logic signed [31:0] v;
		case (s)
			O_D:    v = diff_q;
			O_CHI:  v = chi_q;
			O_SX:   v = sx_q;
			O_SY:   v = sy_q;
			O_SA:   v = sa_q;
			O_RP:   v = rp_q;
			O_RM:   v = rm_q;
			O_AMAX: v = amax_q;
			O_UC:   v = uc_q;
			O_CC:   v = cc_q;
			O_AC:   v = ac_q;
			O_IC:   v = ic_q;
			O_UN:   v = un_q;
			O_CN:   v = cn_q;
			O_AN:   v = an_q;
			O_HALF: v = Q_HALF;
			O_ONE:  v = Q_ONE;
			O_ZERO: v = '0;
			// upwind: lower face takes the center when f <= 0, upper face the neighbor
			O_USEL: v = ((face_q == F_LO) == f_le0) ? uc_q : un_q;
			O_T0:   v = t0_q;
			O_T1:   v = t1_q;
			O_T2:   v = t2_q;
			O_T3:   v = t3_q;
			O_T4:   v = t4_q;
			O_NHC:  v = nhc_q;
			O_FE:   v = fe_q;
			O_FW:   v = fw_q;
			O_FN:   v = fn_q;
			O_FS:   v = fs_q;
			O_FAM:  v = fam_q;
			O_FAP:  v = fap_q;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		opa = pick(uop.a);
		opb = pick(uop.b);
		if (uop.op == U_SUBD && dir_neg) begin
			alu_a = opb;
			alu_b = opa;
		end else begin
			alu_a = opa;
			alu_b = opb;
		end
		case (uop.op)
			U_ADD:   alu_op = ALU_ADD;
			U_SUB:   alu_op = ALU_SUB;
			U_SUBD:  alu_op = ALU_SUB;
			U_MUL:   alu_op = ALU_MUL;
			default: alu_op = ALU_ADD;
		endcase
	end

	cpcs_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.y   (alu_y),
		.sat (alu_sat)
	);

	// final sum is formed wide and saturates once
	assign total = sat64(64'(uc_q) + 64'(t0_q) + 64'(t1_q) + 64'(t2_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (accept && func) state_d = S_CLATCH;
			S_CLATCH: state_d = (inside_q && rd_m[0]) ? S_UOP : S_IDLE;
			S_UOP: begin
				if (uop.last) state_d = (prog_q == P_FINAL) ? S_TOTAL : S_NEXT;
			end
			S_NEXT: begin
				if (face_q == F_END) state_d = S_UOP;
				else if (face_en) state_d = S_NLATCH;
			end
			S_NLATCH: state_d = S_UOP;
			S_TOTAL:  state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs: store read address and scratch write
	always_comb begin
		rd_addr = nb_addr;
		wr_en = 1'b0;
		wr_dst = dst_eff;
		wr_val = alu_y;
		case (state_q)
			S_IDLE: rd_addr = addr_in;
			S_UOP:  wr_en = 1'b1;
			S_NEXT: begin
				// skipped face: flux is zero
				if (face_q != F_END && !face_en) begin
					wr_en = 1'b1;
					wr_dst = face_dst;
					wr_val = '0;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			face_q <= F_E;
			prog_q <= P_NHC;
			pc_q <= '0;
			sat_q <= 1'b0;
			done_q <= 1'b0;
			diff_q <= '0;
			chi_q <= '0;
			sx_q <= '0;
			sy_q <= '0;
			sa_q <= '0;
			rp_q <= '0;
			rm_q <= '0;
			amax_q <= '0;
		end else begin
			state_q <= state_d;
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_DIFF:  diff_q <= cfg_data;
					CFG_CHEMO: chi_q <= cfg_data;
					CFG_SX:    sx_q <= cfg_data;
					CFG_SY:    sy_q <= cfg_data;
					CFG_SA:    sa_q <= cfg_data;
					CFG_RP:    rp_q <= cfg_data;
					CFG_RM:    rm_q <= cfg_data;
					CFG_AMAX:  amax_q <= cfg_data;
					default:   diff_q <= diff_q;
				endcase
			end
			case (state_q)
				S_CLATCH: begin
					sat_q <= 1'b0;
					pc_q <= PC_NHC;
					prog_q <= P_NHC;
					face_q <= F_E;
					if (!(inside_q && rd_m[0])) done_q <= 1'b1;
				end
				S_UOP: begin
					sat_q <= sat_q | alu_sat;
					if (uop.last) begin
						if (prog_q == P_FACE) face_q <= face_t'(face_q + 3'd1);
					end else begin
						pc_q <= pc_q + PC_W'(1);
					end
				end
				S_NEXT: begin
					if (face_q == F_END) begin
						pc_q <= PC_FINAL;
						prog_q <= P_FINAL;
					end else if (!face_en) begin
						face_q <= face_t'(face_q + 3'd1);
					end
				end
				S_NLATCH: begin
					pc_q <= (face_q == F_LO || face_q == F_HI) ? PC_PHENO : PC_FACE;
					prog_q <= P_FACE;
				end
				S_TOTAL: begin
					sat_q <= sat_q | total.flag;
					done_q <= 1'b1;
				end
				default: begin
					pc_q <= pc_q;
				end
			endcase
		end
	end

	// payload: cell latch, scratch, result
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= cell_x;
			y_q <= cell_y;
			k_q <= pheno_bin;
			inside_q <= inside_in;
			c_q <= addr_in;
		end
		if (state_q == S_CLATCH) begin
			uc_q <= rd_u;
			cc_q <= rd_c;
			ac_q <= rd_a;
			ic_q <= rd_i;
			m_q <= rd_m;
			res_q <= '0;
			res_sat_q <= 1'b0;
		end
		if (state_q == S_NLATCH) begin
			un_q <= rd_u;
			cn_q <= rd_c;
			an_q <= rd_a;
		end
		if (state_q == S_TOTAL) begin
			res_q <= total.y;
			res_sat_q <= sat_q | total.flag;
		end
		if (wr_en) begin
			case (wr_dst)
				O_T0:    t0_q <= wr_val;
				O_T1:    t1_q <= wr_val;
				O_T2:    t2_q <= wr_val;
				O_T3:    t3_q <= wr_val;
				O_T4:    t4_q <= wr_val;
				O_NHC:   nhc_q <= wr_val;
				O_FE:    fe_q <= wr_val;
				O_FW:    fw_q <= wr_val;
				O_FN:    fn_q <= wr_val;
				O_FS:    fs_q <= wr_val;
				O_FAM:   fam_q <= wr_val;
				O_FAP:   fap_q <= wr_val;
				default: t4_q <= t4_q;
			endcase
		end
	end

	assign done = done_q;
	assign u_next = res_q;
	assign sat_flag = res_sat_q;

endmodule

FILE: rtl/core/cpcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/cpcs_alu.sv
// Shared arithmetic unit: saturating add, subtract and rounded fixed-point multiply.
module cpcs_alu (
	input  cpcs_pkg::alu_op_t    op,
	input  logic signed [31:0]   a,
	input  logic signed [31:0]   b,
	output logic signed [31:0]   y,
	output logic                 sat
);
	import cpcs_pkg::*;

	logic signed [63:0] wa, wb, wide;
	sat_t r;

	assign wa = 64'(a);
	assign wb = 64'(b);

	always_comb begin
		case (op)
			ALU_ADD: wide = wa + wb;
			ALU_SUB: wide = wa - wb;
			ALU_MUL: wide = (wa * wb + 64'(Q_HALF)) >>> FRAC_BITS;
			default: wide = '0;
		endcase
		r = sat64(wide);
	end

	assign y = r.y;
	assign sat = r.flag;

endmodule
